[rtl/core/smrs_pkg.sv]
// Package for the shutter motor relay sequencer: mode and command codes,
// timer widths, register indexes and the saturating timer add.
// No dependencies.
package smrs_pkg;

	// Timer and register widths
	localparam int TIMER_BITS  = 20;
	localparam int TICK_W      = 10;
	localparam int DEBOUNCE_W  = 16;
	localparam int TIMEOUT_W   = 20;
	localparam int PIN_W       = 4;
	localparam int BUTTON_W    = 16;
	localparam int MODE_W      = 3;
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 5;
	localparam int REG_IDX_W   = 3;

	// Sum width holds a timer plus a tick without loss
	localparam int SUM_W = ((TIMER_BITS > TICK_W) ? TIMER_BITS : TICK_W) + 1;
	// Compare width holds a timer and the widest limit
	localparam int CMP_W = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;

	// Reset values of the configuration registers
	localparam logic [TICK_W-1:0]     TICK_RST     = TICK_W'(10);
	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = DEBOUNCE_W'(200);
	localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = TIMEOUT_W'(60000);
	localparam logic [PIN_W-1:0]      OWN_UP_RST   = PIN_W'(0);
	localparam logic [PIN_W-1:0]      OWN_DN_RST   = PIN_W'(1);
	localparam logic [PIN_W-1:0]      GRP_UP_RST   = PIN_W'(14);
	localparam logic [PIN_W-1:0]      GRP_DN_RST   = PIN_W'(15);

	typedef logic [TIMER_BITS-1:0] timer_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_IDLE    = 3'd0,
		MODE_UP      = 3'd1,
		MODE_DOWN    = 3'd2,
		MODE_RUNNING = 3'd3,
		MODE_STOP    = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		CMD_RELEASE = 2'd0,
		CMD_UP      = 2'd1,
		CMD_DOWN    = 2'd2
	} cmd_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_TICK     = 3'd0,
		REG_DEBOUNCE = 3'd1,
		REG_TIMEOUT  = 3'd2,
		REG_OWN_UP   = 3'd3,
		REG_OWN_DN   = 3'd4,
		REG_GRP_UP   = 3'd5,
		REG_GRP_DN   = 3'd6,
		REG_NONE     = 3'd7
	} reg_idx_t;

	// Add one tick to a timer, saturating at all ones
	function automatic timer_t timer_add(timer_t t, logic [TICK_W-1:0] tick);
		logic [SUM_W-1:0] s;
		logic [SUM_W-1:0] lim;
		timer_t           r;
		s   = SUM_W'(t) + SUM_W'(tick);
		lim = SUM_W'({TIMER_BITS{1'b1}});
		if (s > lim) begin
			r = '1;
		end else begin
			r = s[TIMER_BITS-1:0];
		end
		return r;
	endfunction

endpackage

[rtl/core/shutter_motor_relay_sequencer_top.sv]
// Shutter motor relay sequencer, top level.
// Flow: a word accepted into the input register passes the mode update
// into the result register, which drives the result ports.
// Throughput: one word per cycle unless out_stall holds the result; the
// mode update is one pass of logic between the input and result registers.
// Reset: arst_n clears both stages, enters stop with relays off and
// timers zero, and loads the register defaults. Depends on smrs_pkg.
module shutter_motor_relay_sequencer_top
	import smrs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Button channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [BUTTON_W-1:0]   button_bits,
	// Result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  relay_up_on,
	output logic                  relay_down_on,
	output logic [MODE_W-1:0]     mode_code,
	// Configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	// Configuration registers
	logic [TICK_W-1:0]     tick_q;
	logic [DEBOUNCE_W-1:0] debounce_q;
	logic [TIMEOUT_W-1:0]  timeout_q;
	logic [PIN_W-1:0]      own_up_q;
	logic [PIN_W-1:0]      own_dn_q;
	logic [PIN_W-1:0]      grp_up_q;
	logic [PIN_W-1:0]      grp_dn_q;

	// Pipeline stages
	logic                valid_s1;
	logic [BUTTON_W-1:0] bits_s1;
	logic                valid_s2;
	logic                up_s2;
	logic                down_s2;
	mode_t               mode_s2;
	logic                adv_s1;

	// Sequencer state
	mode_t  mode_q, mode_d;
	timer_t move_q, move_d;
	timer_t run_q, run_d;
	timer_t stop_q, stop_d;
	logic   up_q, up_d;
	logic   down_q, down_d;

	cmd_t     cmd;
	timer_t   move_sum;
	timer_t   run_sum;
	timer_t   stop_sum;
	reg_idx_t cfg_idx;
	logic     cfg_wr;

	// Configuration write and read
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q     <= TICK_RST;
			debounce_q <= DEBOUNCE_RST;
			timeout_q  <= TIMEOUT_RST;
			own_up_q   <= OWN_UP_RST;
			own_dn_q   <= OWN_DN_RST;
			grp_up_q   <= GRP_UP_RST;
			grp_dn_q   <= GRP_DN_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_TICK:     tick_q     <= pwdata[TICK_W-1:0];
				REG_DEBOUNCE: debounce_q <= pwdata[DEBOUNCE_W-1:0];
				REG_TIMEOUT:  timeout_q  <= pwdata[TIMEOUT_W-1:0];
				REG_OWN_UP:   own_up_q   <= pwdata[PIN_W-1:0];
				REG_OWN_DN:   own_dn_q   <= pwdata[PIN_W-1:0];
				REG_GRP_UP:   grp_up_q   <= pwdata[PIN_W-1:0];
				REG_GRP_DN:   grp_dn_q   <= pwdata[PIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_TICK:     prdata = APB_DATA_W'(tick_q);
			REG_DEBOUNCE: prdata = APB_DATA_W'(debounce_q);
			REG_TIMEOUT:  prdata = APB_DATA_W'(timeout_q);
			REG_OWN_UP:   prdata = APB_DATA_W'(own_up_q);
			REG_OWN_DN:   prdata = APB_DATA_W'(own_dn_q);
			REG_GRP_UP:   prdata = APB_DATA_W'(grp_up_q);
			REG_GRP_DN:   prdata = APB_DATA_W'(grp_dn_q);
			default:      prdata = '0;
		endcase
	end

	// Handshake: advance stage 1 when the result register is free or drains
	assign adv_s1   = ~valid_s2 | ~out_stall;
	assign in_stall = valid_s1 & ~adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			bits_s1 <= button_bits;
		end
	end

	// Decode the command in priority order
	always_comb begin
		if (bits_s1[grp_up_q]) begin
			cmd = CMD_UP;
		end else if (bits_s1[grp_dn_q]) begin
			cmd = CMD_DOWN;
		end else if (bits_s1[own_up_q]) begin
			cmd = CMD_UP;
		end else if (bits_s1[own_dn_q]) begin
			cmd = CMD_DOWN;
		end else begin
			cmd = CMD_RELEASE;
		end
	end

	assign move_sum = timer_add(move_q, tick_q);
	assign run_sum  = timer_add(run_q, tick_q);
	assign stop_sum = timer_add(stop_q, tick_q);

	// Next mode, timers and relay drives
	always_comb begin
		mode_d = mode_q;
		move_d = move_q;
		run_d  = run_q;
		stop_d = stop_q;
		up_d   = up_q;
		down_d = down_q;
		case (mode_q)
			MODE_IDLE: begin
				if (cmd == CMD_UP) begin
					mode_d = MODE_UP;
					up_d   = 1'b1;
					down_d = 1'b0;
					move_d = '0;
				end else if (cmd == CMD_DOWN) begin
					mode_d = MODE_DOWN;
					up_d   = 1'b0;
					down_d = 1'b1;
					move_d = '0;
				end
			end
			MODE_UP, MODE_DOWN: begin
				if ((mode_q == MODE_UP && cmd == CMD_DOWN) ||
				    (mode_q == MODE_DOWN && cmd == CMD_UP)) begin
					mode_d = MODE_STOP;
					up_d   = 1'b0;
					down_d = 1'b0;
					stop_d = '0;
				end else begin
					move_d = move_sum;
					if (CMP_W'(move_sum) >= CMP_W'(debounce_q)) begin
						mode_d = MODE_RUNNING;
						run_d  = '0;
					end
				end
			end
			MODE_RUNNING: begin
				if (cmd != CMD_RELEASE ||
				    CMP_W'(run_sum) >= CMP_W'(timeout_q)) begin
					mode_d = MODE_STOP;
					up_d   = 1'b0;
					down_d = 1'b0;
					stop_d = '0;
				end
				if (cmd == CMD_RELEASE) begin
					run_d = run_sum;
				end
			end
			default: begin
				if (CMP_W'(stop_q) > CMP_W'(debounce_q)) begin
					mode_d = MODE_IDLE;
				end else begin
					stop_d = stop_sum;
				end
			end
		endcase
	end

	// Commit state when a word leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_STOP;
			move_q <= '0;
			run_q  <= '0;
			stop_q <= '0;
			up_q   <= 1'b0;
			down_q <= 1'b0;
		end else if (valid_s1 && adv_s1) begin
			mode_q <= mode_d;
			move_q <= move_d;
			run_q  <= run_d;
			stop_q <= stop_d;
			up_q   <= up_d;
			down_q <= down_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			up_s2   <= up_d;
			down_s2 <= down_d;
			mode_s2 <= mode_d;
		end
	end

	assign out_valid     = valid_s2;
	assign relay_up_on   = up_s2;
	assign relay_down_on = down_s2;
	assign mode_code     = mode_s2;

endmodule
